>>> hdl/fpba_pkg.sv
// package: types and constants for the fit policy block allocator
`timescale 1ns / 1ps
package fpba_pkg;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // status codes
    localparam logic [1:0] ST_LOADED    = 2'd0;
    localparam logic [1:0] ST_ALLOCATED = 2'd1;
    localparam logic [1:0] ST_WAITING   = 2'd2;

    // placement policy codes, the unused code acts as first fit
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // register indexes on the configuration port
    localparam logic REG_FIT_POLICY  = 1'b0;
    localparam logic REG_BLOCK_COUNT = 1'b1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // input transaction
    typedef struct packed {
        logic        operation;
        logic [3:0]  block_select;
        logic [15:0] size_value;
    } t_alloc_req;

    // result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  granted_block;
        logic [15:0] leftover;
    } t_alloc_rsp;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

>>> hdl/fpba_store.sv
// block size store: one write port, one registered read port, valid bits for reset
`timescale 1ns / 1ps
module fpba_store #(
    parameter int NUM_BLOCKS = 16,
    parameter int IDX_W      = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [15:0]      i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [15:0]      o_rd_data
);

    logic [15:0]           r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [15:0]           r_rd_data;
    logic                  r_rd_valid;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // valid bits, cleared at reset so unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : 16'd0;

endmodule

>>> hdl/fit_policy_block_allocator.sv
// Fit policy block allocator: a load is handled on accept; result on o_done the next cycle.
// An allocate request scans L = min(block_count, NUM_BLOCKS) blocks: after the accept cycle,
// one store read per block through the shared compare unit, then read latency, drain and
// update steps; result on o_done the next cycle. busy is high from scan to update; with no
// blocks in use a request answers like a load. Synchronous reset clears the configuration
// and marks every block as zero size. Results are shown for one cycle; no receiver stall.
`timescale 1ns / 1ps
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fpba_pkg::t_alloc_req       i_req,
    output logic                       o_done,
    output fpba_pkg::t_alloc_rsp       o_rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fpba_pkg::APB_AW-1:0] paddr,
    input  logic [fpba_pkg::APB_DW-1:0] pwdata,
    output logic [fpba_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // configuration registers
    logic [1:0] r_fit_policy;
    logic [4:0] r_block_count;

    // sequencer and datapath registers
    t_state           r_state, n_state;
    logic [15:0]      r_size, n_size;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_pend_idx, n_pend_idx;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_best_idx, n_best_idx;
    logic [15:0]      r_best_val, n_best_val;
    logic             r_done, n_done;
    t_alloc_rsp       r_rsp, n_rsp;

    // store port signals
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      wr_data;
    logic [15:0]      rd_data;

    // helpers
    logic             accept;
    logic             cfg_wr;
    logic [31:0]      cnt_ext;
    logic [CNT_W-1:0] limit_now;
    logic [IDX_W+3:0] sel_ext;
    logic             sel_in_range;
    logic [IDX_W+3:0] best_ext;
    logic             fits;
    logic             better;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign o_done  = r_done;
    assign o_rsp   = r_rsp;

    // block count saturates at the store depth
    assign cnt_ext   = 32'(r_block_count);
    assign limit_now = (cnt_ext > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(cnt_ext);

    // load address and range check
    assign sel_ext      = (IDX_W+4)'(i_req.block_select);
    assign sel_in_range = (32'(i_req.block_select) < NUM_BLOCKS);
    assign best_ext     = (IDX_W+4)'(r_best_idx);

    // shared compare unit
    assign fits   = (r_size <= rd_data);
    assign better = ((r_fit_policy == POL_BEST) && (rd_data < r_best_val)) ||
                    ((r_fit_policy == POL_WORST) && (rd_data > r_best_val));

    // configuration write and read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy  <= POL_FIRST;
            r_block_count <= 5'd0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FIT_POLICY:  r_fit_policy  <= pwdata[1:0];
                REG_BLOCK_COUNT: r_block_count <= pwdata[4:0];
                default:         r_fit_policy  <= r_fit_policy;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIT_POLICY:  prdata = APB_DW'(r_fit_policy);
            REG_BLOCK_COUNT: prdata = APB_DW'(r_block_count);
            default:         prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req.operation == OP_ALLOC) && (limit_now != '0)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if ((r_ptr == r_limit) && !r_pend) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath control and result
    always_comb begin
        n_size     = r_size;
        n_limit    = r_limit;
        n_ptr      = r_ptr;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_val = r_best_val;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        wr_en      = 1'b0;
        wr_addr    = sel_ext[IDX_W-1:0];
        wr_data    = i_req.size_value;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_size  = i_req.size_value;
                    n_limit = limit_now;
                    n_ptr   = '0;
                    n_found = 1'b0;
                    if (i_req.operation == OP_LOAD) begin
                        wr_en  = sel_in_range;
                        n_done = 1'b1;
                        n_rsp  = '{status: ST_LOADED, granted_block: 4'd0, leftover: 16'd0};
                    end else if (limit_now == '0) begin
                        n_done = 1'b1;
                        n_rsp  = '{status: ST_WAITING, granted_block: 4'd0, leftover: 16'd0};
                    end
                end
            end
            S_SCAN: begin
                // issue the next read
                if (r_ptr != r_limit) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_ptr[IDX_W-1:0];
                    n_ptr      = r_ptr + CNT_W'(1);
                end
                // judge the block read last cycle
                if (r_pend && fits) begin
                    if (!r_found || better) begin
                        n_found    = 1'b1;
                        n_best_idx = r_pend_idx;
                        n_best_val = rd_data;
                    end
                end
            end
            S_FINISH: begin
                n_done = 1'b1;
                if (r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_best_idx;
                    wr_data = r_best_val - r_size;
                    n_rsp   = '{status: ST_ALLOCATED, granted_block: best_ext[3:0],
                                leftover: r_best_val - r_size};
                end else begin
                    n_rsp   = '{status: ST_WAITING, granted_block: 4'd0, leftover: 16'd0};
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_done  <= n_done;
            r_ptr   <= n_ptr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_limit    <= n_limit;
        r_pend_idx <= n_pend_idx;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_rsp      <= n_rsp;
    end

    // block size store
    fpba_store #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (r_ptr[IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

endmodule
